>>> rtl/core/smc_pkg.sv
// Shared sizes, selector codes and controller/datapath interface types for the string matcher.
package smc_pkg;

    // Buffer depth of each of the text and pattern stores
    localparam int MAX_LEN = 128;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Selector codes carried on the input tuser
    localparam logic [1:0] FUNC_PAT    = 2'd0;
    localparam logic [1:0] FUNC_TXT    = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_pat;
        logic load_txt;
        logic start;
        logic pal_clr;
        logic srch_init;
        logic inc_i;
        logic next_start;
        logic found_set;
        logic found_clr;
        logic result_load;
    } smc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pal_done;
        logic pal_mis;
        logic srch_mis;
        logic pat_empty;
        logic pat_long;
        logic k_last;
        logic start_last;
        logic out_busy;
    } smc_sts_t;

endpackage

>>> rtl/core/smc_datapath.sv
// Datapath of the string matcher: byte stores, counters, index registers and result register.
module smc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  smc_pkg::smc_cmd_t   cmd,
    output smc_pkg::smc_sts_t   sts,
    input  logic [7:0]          char_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_data
);

    logic [7:0]                 text_mem [smc_pkg::MAX_LEN];
    logic [7:0]                 pat_mem  [smc_pkg::MAX_LEN];

    logic [smc_pkg::CNT_W-1:0]  tc_reg, tc_next;
    logic [smc_pkg::CNT_W-1:0]  pc_reg, pc_next;
    logic                       dropped_reg, dropped_next;
    logic [smc_pkg::CNT_W-1:0]  i_reg, i_next;
    logic [smc_pkg::CNT_W-1:0]  start_reg, start_next;
    logic                       pal_reg, pal_next;
    logic                       found_reg, found_next;
    logic                       out_valid_reg, out_valid_next;
    logic [15:0]                out_data_reg, out_data_next;

    logic [7:0]                 ta_reg, tb_reg, pd_reg;
    logic [smc_pkg::CNT_W-1:0]  addr_a, addr_b;
    logic                       tc_full, pc_full;

    // Read addresses: port A walks start+i, port B walks the text from its tail
    assign addr_a  = start_reg + i_reg;
    assign addr_b  = tc_reg - {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1} - i_reg;
    assign tc_full = (tc_reg == smc_pkg::CNT_W'(smc_pkg::MAX_LEN));
    assign pc_full = (pc_reg == smc_pkg::CNT_W'(smc_pkg::MAX_LEN));

    // Text store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load_txt && !tc_full)
        begin
            text_mem[tc_reg[smc_pkg::ADDR_W-1:0]] <= char_code;
        end
        ta_reg <= text_mem[addr_a[smc_pkg::ADDR_W-1:0]];
        tb_reg <= text_mem[addr_b[smc_pkg::ADDR_W-1:0]];
    end

    // Pattern store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_pat && !pc_full)
        begin
            pat_mem[pc_reg[smc_pkg::ADDR_W-1:0]] <= char_code;
        end
        pd_reg <= pat_mem[i_reg[smc_pkg::ADDR_W-1:0]];
    end

    // Status toward the controller
    assign sts.pal_done   = (i_reg >= (tc_reg >> 1));
    assign sts.pal_mis    = (ta_reg != tb_reg);
    assign sts.srch_mis   = (ta_reg != pd_reg);
    assign sts.pat_empty  = (pc_reg == '0);
    assign sts.pat_long   = (pc_reg > tc_reg);
    assign sts.k_last     = (i_reg == pc_reg - {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1});
    assign sts.start_last = (start_reg == tc_reg - pc_reg);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // Next-state logic for counters, indices, flags and the result beat
    always_comb
    begin
        tc_next        = tc_reg;
        pc_next        = pc_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        start_next     = start_reg;
        pal_next       = pal_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_txt)
        begin
            if (tc_full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                tc_next = tc_reg + {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
        end

        if (cmd.load_pat)
        begin
            if (pc_full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                pc_next = pc_reg + {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
        end

        if (cmd.start || cmd.srch_init)
        begin
            i_next     = '0;
            start_next = '0;
        end
        if (cmd.start)
        begin
            pal_next = 1'b1;
        end
        if (cmd.pal_clr)
        begin
            pal_next = 1'b0;
        end
        if (cmd.inc_i)
        begin
            i_next = i_reg + {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
        if (cmd.next_start)
        begin
            i_next     = '0;
            start_next = start_reg + {{(smc_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
        if (cmd.found_set)
        begin
            found_next = 1'b1;
        end
        if (cmd.found_clr)
        begin
            found_next = 1'b0;
        end

        // Result: equality is a full-length match at the only start position
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0000, dropped_reg, found_reg,
                              found_reg && (tc_reg == pc_reg), pal_reg, 8'(tc_reg)};
            tc_next        = '0;
            pc_next        = '0;
            dropped_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg        <= '0;
            pc_reg        <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tc_reg        <= tc_next;
            pc_reg        <= pc_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        start_reg    <= start_next;
        pal_reg      <= pal_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/smc_controller.sv
// Controller state machine of the string matcher: loading, palindrome walk, naive search.
module smc_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  smc_pkg::smc_sts_t   sts,
    output smc_pkg::smc_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PAL_RD   = 7'b0000010,
        ST_PAL_CMP  = 7'b0000100,
        ST_SRCH_CHK = 7'b0001000,
        ST_SRCH_RD  = 7'b0010000,
        ST_SRCH_CMP = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } smc_state_t;

    smc_state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        smc_pkg::FUNC_PAT:    cmd.load_pat = 1'b1;
                        smc_pkg::FUNC_TXT:    cmd.load_txt = 1'b1;
                        smc_pkg::FUNC_FINISH:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_PAL_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAL_RD:
            begin
                if (sts.pal_done)
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SRCH_CHK;
                end
                else
                begin
                    state_next = ST_PAL_CMP;
                end
            end
            ST_PAL_CMP:
            begin
                if (sts.pal_mis)
                begin
                    cmd.pal_clr   = 1'b1;
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SRCH_CHK;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = ST_PAL_RD;
                end
            end
            ST_SRCH_CHK:
            begin
                if (sts.pat_empty)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = ST_RESULT;
                end
                else if (sts.pat_long)
                begin
                    cmd.found_clr = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (sts.srch_mis)
                begin
                    if (sts.start_last)
                    begin
                        cmd.found_clr = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        cmd.next_start = 1'b1;
                        state_next     = ST_SRCH_RD;
                    end
                end
                else if (sts.k_last)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result never overwrites a beat still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !sts.out_busy)
        else $error("result loaded while output stalled");

    // Every search compare follows its read cycle
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP) |-> ($past(state_reg) == ST_SRCH_RD))
        else $error("search compare without preceding read");

    // A finish beat always leaves idle
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == smc_pkg::FUNC_FINISH) |=> (state_reg != ST_IDLE))
        else $error("finish beat did not start the compare");

    // The found flag is never set and cleared together
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.found_set && cmd.found_clr))
        else $error("conflicting found commands");

endmodule

>>> rtl/core/string_match_compare.sv
// Top level of the string matcher: stream ports around the controller and the datapath.
//
// Usage: the input stream carries one beat per character. tuser selects the
// action (append to pattern, append to text, finish); tdata holds the byte.
// Append beats are taken one per cycle while the controller is idle and give
// no output. Bytes beyond the buffer depth of either store are dropped and
// flagged as overflow. A finish beat walks the text from both ends for the
// palindrome check, then runs the naive search; each byte compare is a
// registered memory read, then a compare. No input beat is taken meanwhile.
// The result goes to an output register; appends are taken while it waits.
// If the receiver stalls, the next finish holds in its last step until the
// pending beat is taken. Reset empties both buffers, clears the overflow flag
// and drops any pending result.
module string_match_compare
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] text_len, [8] palindrome_flag,
                                        // [9] equal_flag, [10] found_flag,
                                        // [11] overflow_flag, [15:12] zero
);

    smc_pkg::smc_cmd_t cmd;
    smc_pkg::smc_sts_t sts;

    // Sequencing
    smc_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .func     (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores and compare logic
    smc_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .char_code (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> test/string_match_compare_checker.sv
// Checker for the string matcher: tracks loaded bytes, predicts each finish result, compares.
`timescale 1ns / 100ps

module string_match_compare_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [7:0] text_len, [8] palindrome_flag,
                                        // [9] equal_flag, [10] found_flag,
                                        // [11] overflow_flag, [15:12] zero
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] text_len;
        logic       palin;
        logic       equal;
        logic       found;
        logic       overflow;
    } verdict_t;

    // Shadow copy of both stores
    logic [7:0] text_buf [smc_pkg::MAX_LEN];
    logic [7:0] pat_buf  [smc_pkg::MAX_LEN];
    int         text_cnt;
    int         pat_cnt;
    logic       spill;

    verdict_t   verdict_q [$];
    verdict_t   want;
    int         mism;

    // Result of a finish beat on the current buffer contents
    function automatic verdict_t judge_strings();
        verdict_t v;
        int       i;
        int       s;
        int       k;
        logic     hit;
        v.text_len = text_cnt[7:0];
        v.overflow = spill;

        v.palin = 1'b1;
        for (i = 0; i < text_cnt / 2; i++)
            if (text_buf[i] != text_buf[text_cnt - 1 - i])
                v.palin = 1'b0;

        v.equal = (text_cnt == pat_cnt);
        if (v.equal)
            for (i = 0; i < text_cnt; i++)
                if (text_buf[i] != pat_buf[i])
                    v.equal = 1'b0;

        // naive search; empty pattern hits at position zero
        v.found = 1'b0;
        if (pat_cnt <= text_cnt)
            for (s = 0; s <= text_cnt - pat_cnt && !v.found; s++)
            begin
                hit = 1'b1;
                for (k = 0; k < pat_cnt; k++)
                    if (text_buf[s + k] != pat_buf[k])
                        hit = 1'b0;
                if (hit)
                    v.found = 1'b1;
            end
        return v;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            mism++;
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_cnt = 0;
            pat_cnt  = 0;
            spill    = 1'b0;
            mism     = 0;
            verdict_q.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // output beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mism++;
                    $error("result beat with nothing pending: tdata %h", m_axis_tdata);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("text_len", want.text_len, m_axis_tdata[7:0]);
                    check_field("palindrome_flag", want.palin, m_axis_tdata[8]);
                    check_field("equal_flag", want.equal, m_axis_tdata[9]);
                    check_field("found_flag", want.found, m_axis_tdata[10]);
                    check_field("overflow_flag", want.overflow, m_axis_tdata[11]);
                    check_field("pad", 0, m_axis_tdata[15:12]);
                end
            end

            // input beat updates the shadow state
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    smc_pkg::FUNC_PAT:
                    begin
                        if (pat_cnt < smc_pkg::MAX_LEN)
                        begin
                            pat_buf[pat_cnt] = s_axis_tdata;
                            pat_cnt++;
                        end
                        else
                            spill = 1'b1;
                    end
                    smc_pkg::FUNC_TXT:
                    begin
                        if (text_cnt < smc_pkg::MAX_LEN)
                        begin
                            text_buf[text_cnt] = s_axis_tdata;
                            text_cnt++;
                        end
                        else
                            spill = 1'b1;
                    end
                    smc_pkg::FUNC_FINISH:
                    begin
                        verdict_q.push_back(judge_strings());
                        text_cnt = 0;
                        pat_cnt  = 0;
                        spill    = 1'b0;
                    end
                    default: ;  // unused selector, no effect
                endcase
            end

            pending    <= verdict_q.size();
            fail_count <= mism;
        end
    end

endmodule

>>> test/string_match_compare_tb.sv
// Testbench top for the string matcher: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module string_match_compare_tb;

    localparam logic [1:0] FUNC_IDLE   = 2'd3;  // selector the block ignores
    localparam int         ITEM_GOAL   = 1500;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef logic [7:0] byte_q_t [$];

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] char_code
    logic [1:0]  s_axis_tuser  = 2'd0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] text_len, [8] palindrome_flag,
                                         // [9] equal_flag, [10] found_flag,
                                         // [11] overflow_flag, [15:12] zero
    int          fail_count;
    int          pending;
    int          beats_sent = 0;
    bit          idle_on    = 1'b1;

    string_match_compare dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    string_match_compare_checker match_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stall bursts while idling is on
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // One input beat; returns at the accepting edge or after an idle burst
    task automatic send_beat(input logic [1:0] func, input logic [7:0] ch);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= ch;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (func != FUNC_IDLE)
            beats_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Sender holds off until every predicted result has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic byte_q_t make_str(input int len, input logic [7:0] base, input int span);
        byte_q_t s;
        int      j;
        for (j = 0; j < len; j++)
            s.push_back(base + 8'($urandom_range(0, span)));
        return s;
    endfunction

    // Load pattern and text bytes in random interleaving, then finish
    task automatic play_case(input byte_q_t pat, input byte_q_t txt, input bit noisy);
        int p;
        int t;
        p = 0;
        t = 0;
        while (p < pat.size() || t < txt.size())
        begin
            if (noisy && $urandom_range(0, 4) == 0)
                send_beat(FUNC_IDLE, 8'($urandom_range(0, 255)));
            if (t >= txt.size() || (p < pat.size() && $urandom_range(0, 1) == 1))
            begin
                send_beat(smc_pkg::FUNC_PAT, pat[p]);
                p++;
            end
            else
            begin
                send_beat(smc_pkg::FUNC_TXT, txt[t]);
                t++;
            end
        end
        send_beat(smc_pkg::FUNC_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict
    initial
    begin
        byte_q_t    pat;
        byte_q_t    txt;
        byte_q_t    half;
        logic [7:0] base;
        int         span;
        int         kind;
        int         n;
        int         m;
        int         j;
        bit         mid_drained;

        mid_drained = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty buffers
        play_case(pat, txt, 1'b0);
        // single extreme byte inside a palindromic text
        pat = '{8'hFF};
        txt = '{8'h00, 8'hFF, 8'h00};
        play_case(pat, txt, 1'b0);
        // pattern longer than text
        pat = '{8'h01, 8'h02, 8'h03};
        txt = '{8'h01, 8'h02};
        play_case(pat, txt, 1'b0);
        // identical strings
        pat = '{8'hFF, 8'h80};
        txt = '{8'hFF, 8'h80};
        play_case(pat, txt, 1'b0);
        // ignored selector, then empty pattern against a text with a zero byte
        send_beat(FUNC_IDLE, 8'hAA);
        pat.delete();
        txt = '{8'h7F, 8'h00};
        play_case(pat, txt, 1'b0);
        // pattern absent
        pat = '{8'h01, 8'h02};
        txt = '{8'h01, 8'h03, 8'h02};
        play_case(pat, txt, 1'b0);
        hold_until_drained();

        // random cases
        while (beats_sent < ITEM_GOAL)
        begin
            if (beats_sent > ITEM_GOAL - 200)
                idle_on = 1'b0;
            else if ($urandom_range(0, 7) == 0)
                idle_on = !idle_on;
            if (!mid_drained && beats_sent > ITEM_GOAL / 2)
            begin
                hold_until_drained();
                mid_drained = 1'b1;
            end

            pat.delete();
            txt.delete();
            base = 8'($urandom_range(0, 255));
            span = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3);
            kind = $urandom_range(0, 99);

            if (kind < 30)
            begin
                // pattern planted inside the text
                pat = make_str($urandom_range(0, 5), base, span);
                txt = make_str($urandom_range(0, 6), base, span);
                foreach (pat[j]) txt.push_back(pat[j]);
                half = make_str($urandom_range(0, 6), base, span);
                foreach (half[j]) txt.push_back(half[j]);
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 45)
            begin
                // palindromic text, odd or even length
                half = make_str($urandom_range(0, 6), base, span);
                txt = half;
                if ($urandom_range(0, 1) == 1)
                    txt.push_back(base + 8'($urandom_range(0, span)));
                for (j = half.size() - 1; j >= 0; j--)
                    txt.push_back(half[j]);
                pat = make_str($urandom_range(0, 3), base, span);
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 55)
            begin
                txt = make_str($urandom_range(0, 10), base, span);
                pat = txt;
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 80)
            begin
                txt = make_str($urandom_range(0, 12), base, span);
                pat = make_str($urandom_range(0, 6), base, span);
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 85)
            begin
                // text is a prefix of a longer pattern
                txt = make_str($urandom_range(0, 4), base, span);
                pat = txt;
                half = make_str($urandom_range(1, 3), base, span);
                foreach (half[j]) pat.push_back(half[j]);
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 88)
            begin
                // one buffer overfills, extra bytes dropped
                if ($urandom_range(0, 1) == 1)
                begin
                    txt = make_str($urandom_range(smc_pkg::MAX_LEN + 1, smc_pkg::MAX_LEN + 6),
                                   8'd0, 255);
                    pat = make_str($urandom_range(0, 4), base, span);
                end
                else
                begin
                    pat = make_str($urandom_range(smc_pkg::MAX_LEN + 1, smc_pkg::MAX_LEN + 6),
                                   8'd0, 255);
                    txt = make_str($urandom_range(0, 8), base, span);
                end
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 90)
            begin
                // long run of one byte: every start position nearly matches
                n = $urandom_range(100, smc_pkg::MAX_LEN);
                m = $urandom_range(24, 64);
                for (j = 0; j < m - 1; j++)
                    pat.push_back(base);
                pat.push_back(base + 8'd1);
                for (j = 0; j < n; j++)
                    txt.push_back(base);
                if ($urandom_range(0, 1) == 1)
                    txt[n - 1] = base + 8'd1;
                play_case(pat, txt, 1'b0);
            end
            else if (kind < 95)
            begin
                // ignored beats mixed into a case
                txt = make_str($urandom_range(0, 6), base, span);
                pat = make_str($urandom_range(0, 3), base, span);
                play_case(pat, txt, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        // wind down
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
